### sv/bfw_pkg.sv
// Shared constants, types and the cosine table of the brush falloff weight unit.
package bfw_pkg;

  // Field formats
  localparam int DIST_BITS = 16;
  localparam int FRAC_BITS = 12;
  localparam int ONE       = 1 << FRAC_BITS;

  // Datapath widths
  localparam int DW        = (DIST_BITS > FRAC_BITS + 1) ? DIST_BITS : FRAC_BITS + 1;
  localparam int TAB_SHIFT = 16 - FRAC_BITS;
  localparam int HALF_TAB  = (1 << TAB_SHIFT) >> 1;
  localparam int MW        = 17;
  localparam int PW        = 2 * MW;
  localparam int SQ_W      = 2 * FRAC_BITS;
  localparam int IN_W      = ((DIST_BITS + 7) / 8) * 8;
  localparam int OUT_W     = ((FRAC_BITS + 1 + 7) / 8) * 8;

  // Register indexes
  localparam logic [1:0] REG_RADIUS  = 2'd0;
  localparam logic [1:0] REG_FALLOFF = 2'd1;
  localparam logic [1:0] REG_CURVE   = 2'd2;

  typedef enum logic [1:0] {
    CURVE_LINEAR,
    CURVE_COSINE,
    CURVE_SPHERE,
    CURVE_TIP
  } bfw_curve_t;

  // Flags that ride along with an item
  typedef struct packed {
    logic outside;
    logic full;
  } bfw_tag_t;

  // Curve stage result handed to the root pipeline
  typedef struct packed {
    logic                  use_sqrt;
    logic [FRAC_BITS:0]    weight;
    logic [SQ_W-1:0]       rad;
  } bfw_curve_out_t;

  // Q1.16 table of 0.5(1+cos(pi k/16))
  function automatic logic [16:0] cos_tab(input logic [4:0] k);
    logic [16:0] v;
    case (k)
      5'd0:  v = 17'd65536;
      5'd1:  v = 17'd64906;
      5'd2:  v = 17'd63042;
      5'd3:  v = 17'd60014;
      5'd4:  v = 17'd55938;
      5'd5:  v = 17'd50973;
      5'd6:  v = 17'd45308;
      5'd7:  v = 17'd39161;
      5'd8:  v = 17'd32768;
      5'd9:  v = 17'd26375;
      5'd10: v = 17'd20228;
      5'd11: v = 17'd14563;
      5'd12: v = 17'd9598;
      5'd13: v = 17'd5522;
      5'd14: v = 17'd2494;
      5'd15: v = 17'd630;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

endpackage

### sv/bfw_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module bfw_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [bfw_pkg::DW-1:0]       in_rem,
  input  logic [bfw_pkg::DW-1:0]       in_divisor,
  input  bfw_pkg::bfw_tag_t            in_tag,
  output logic                         out_valid,
  output logic [bfw_pkg::FRAC_BITS-1:0] out_quo,
  output bfw_pkg::bfw_tag_t            out_tag
);
  import bfw_pkg::*;

  localparam int N = FRAC_BITS;

  logic           vld      [N];
  logic [DW-1:0]  rem      [N];
  logic [N-1:0]   quo      [N];
  bfw_tag_t       tag      [N];

  logic           vld_src  [N];
  logic [DW-1:0]  rem_src  [N];
  logic [N-1:0]   quo_src  [N];
  bfw_tag_t       tag_src  [N];

  logic [DW:0]    shl      [N];
  logic           ge       [N];
  logic [DW-1:0]  rem_next [N];
  logic [N-1:0]   quo_next [N];

  // Chain each stage to the one before it
  for (genvar i = 0; i < N; i++) begin : g_src
    if (i == 0) begin : g_first
      assign vld_src[i] = in_valid;
      assign rem_src[i] = in_rem;
      assign quo_src[i] = '0;
      assign tag_src[i] = in_tag;
    end else begin : g_next
      assign vld_src[i] = vld[i-1];
      assign rem_src[i] = rem[i-1];
      assign quo_src[i] = quo[i-1];
      assign tag_src[i] = tag[i-1];
    end
  end

  // Shift, trial subtract, keep the bit
  always_comb begin
    for (int i = 0; i < N; i++) begin
      shl[i]      = {rem_src[i], 1'b0};
      ge[i]       = shl[i] >= {1'b0, in_divisor};
      rem_next[i] = ge[i] ? DW'(shl[i] - {1'b0, in_divisor}) : shl[i][DW-1:0];
      quo_next[i] = {quo_src[i][N-2:0], ge[i]};
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < N; i++) vld[i] <= 1'b0;
    end else if (en) begin
      for (int i = 0; i < N; i++) vld[i] <= vld_src[i];
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < N; i++) begin
        rem[i] <= rem_next[i];
        quo[i] <= quo_next[i];
        tag[i] <= tag_src[i];
      end
    end
  end

  assign out_valid = vld[N-1];
  assign out_quo   = quo[N-1];
  assign out_tag   = tag[N-1];

endmodule

### sv/bfw_curve.sv
// Curve evaluation: one shared multiplier stage, then the per-curve finish.
module bfw_curve (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [bfw_pkg::FRAC_BITS-1:0] in_t,
  input  bfw_pkg::bfw_tag_t             in_tag,
  input  bfw_pkg::bfw_curve_t           curve,
  output logic                          out_valid,
  output bfw_pkg::bfw_curve_out_t       out_res
);
  import bfw_pkg::*;

  localparam logic [SQ_W:0] ONE_SQ = (SQ_W + 1)'(1) << SQ_W;

  logic [FRAC_BITS:0]   r;
  logic [15:0]          p16;
  logic [16:0]          tab_a;
  logic [16:0]          tab_b;
  logic [MW-1:0]        opa;
  logic [MW-1:0]        opb;

  logic                 c1_vld;
  logic [PW-1:0]        c1_prod;
  logic [16:0]          c1_a;
  logic [FRAC_BITS-1:0] c1_t;
  bfw_tag_t             c1_tag;

  logic [PW-1:0]        cos_rnd;
  logic [17:0]          cos_v;
  logic [17:0]          cos_w;
  logic [PW-1:0]        tip_w;
  logic [FRAC_BITS:0]   w_sel;
  bfw_curve_out_t       res_next;

  logic                 c2_vld;
  bfw_curve_out_t       c2_res;

  // Pick multiplier operands for the active curve
  always_comb begin
    r     = (FRAC_BITS + 1)'(ONE) - {1'b0, in_t};
    p16   = 16'(in_t) << TAB_SHIFT;
    tab_a = cos_tab({1'b0, p16[15:12]});
    tab_b = cos_tab({1'b0, p16[15:12]} + 5'd1);
    case (curve)
      CURVE_COSINE: begin
        opa = tab_a - tab_b;
        opb = MW'(p16[11:0]);
      end
      CURVE_SPHERE: begin
        opa = MW'(in_t);
        opb = MW'(in_t);
      end
      CURVE_TIP: begin
        opa = MW'(r);
        opb = MW'(r);
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  // Finish each curve from the product
  always_comb begin
    cos_rnd = (c1_prod + PW'(2048)) >> 12;
    cos_v   = {1'b0, c1_a} - {1'b0, cos_rnd[16:0]};
    cos_w   = (cos_v + 18'(HALF_TAB)) >> TAB_SHIFT;
    tip_w   = (c1_prod + PW'(ONE / 2)) >> FRAC_BITS;
    case (curve)
      CURVE_COSINE: w_sel = cos_w[FRAC_BITS:0];
      CURVE_TIP:    w_sel = tip_w[FRAC_BITS:0];
      CURVE_SPHERE: w_sel = '0;
      default:      w_sel = (FRAC_BITS + 1)'(ONE) - {1'b0, c1_t};
    endcase
    res_next.rad      = SQ_W'(ONE_SQ - c1_prod[SQ_W:0]);
    res_next.use_sqrt = (curve == CURVE_SPHERE) && !c1_tag.outside && !c1_tag.full;
    if (c1_tag.outside) begin
      res_next.weight = '0;
    end else if (c1_tag.full) begin
      res_next.weight = (FRAC_BITS + 1)'(ONE);
    end else begin
      res_next.weight = w_sel;
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      c1_vld <= 1'b0;
      c2_vld <= 1'b0;
    end else if (en) begin
      c1_vld <= in_valid;
      c2_vld <= c1_vld;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      c1_prod <= opa * opb;
      c1_a    <= tab_a;
      c1_t    <= in_t;
      c1_tag  <= in_tag;
      c2_res  <= res_next;
    end
  end

  assign out_valid = c2_vld;
  assign out_res   = c2_res;

endmodule

### sv/bfw_sqrt.sv
// Pipelined integer square root, one root bit per stage, for the sphere curve.
module bfw_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  bfw_pkg::bfw_curve_out_t     in_res,
  output logic                        out_valid,
  output logic [bfw_pkg::FRAC_BITS:0] out_weight
);
  import bfw_pkg::*;

  localparam int N = FRAC_BITS;

  logic              vld      [N];
  logic [N+1:0]      rem      [N];
  logic [N-1:0]      root     [N];
  logic [SQ_W-1:0]   val      [N];
  logic              use_sq   [N];
  logic [N:0]        wgt      [N];

  logic              vld_src  [N];
  logic [N+1:0]      rem_src  [N];
  logic [N-1:0]      root_src [N];
  logic [SQ_W-1:0]   val_src  [N];
  logic              use_src  [N];
  logic [N:0]        wgt_src  [N];

  logic [N+3:0]      rem2     [N];
  logic [N+3:0]      trial    [N];
  logic              ge       [N];
  logic [N+1:0]      rem_next [N];

  // Chain each stage to the one before it
  for (genvar i = 0; i < N; i++) begin : g_src
    if (i == 0) begin : g_first
      assign vld_src[i]  = in_valid;
      assign rem_src[i]  = '0;
      assign root_src[i] = '0;
      assign val_src[i]  = in_res.rad;
      assign use_src[i]  = in_res.use_sqrt;
      assign wgt_src[i]  = in_res.weight;
    end else begin : g_next
      assign vld_src[i]  = vld[i-1];
      assign rem_src[i]  = rem[i-1];
      assign root_src[i] = root[i-1];
      assign val_src[i]  = val[i-1];
      assign use_src[i]  = use_sq[i-1];
      assign wgt_src[i]  = wgt[i-1];
    end
  end

  // Bring down two bits, try root*4+1
  always_comb begin
    for (int i = 0; i < N; i++) begin
      rem2[i]     = {rem_src[i], val_src[i][SQ_W-1 -: 2]};
      trial[i]    = (N + 4)'({root_src[i], 2'b01});
      ge[i]       = rem2[i] >= trial[i];
      rem_next[i] = ge[i] ? (N + 2)'(rem2[i] - trial[i]) : rem2[i][N+1:0];
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < N; i++) vld[i] <= 1'b0;
    end else if (en) begin
      for (int i = 0; i < N; i++) vld[i] <= vld_src[i];
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < N; i++) begin
        rem[i]    <= rem_next[i];
        root[i]   <= {root_src[i][N-2:0], ge[i]};
        val[i]    <= val_src[i] << 2;
        use_sq[i] <= use_src[i];
        wgt[i]    <= wgt_src[i];
      end
    end
  end

  assign out_valid  = vld[N-1];
  assign out_weight = use_sq[N-1] ? {1'b0, root[N-1]} : wgt[N-1];

endmodule

### sv/radial_brush_falloff_weight_unit.sv
// Top level: config registers, input stage, two dividers, curve and root pipelines.
// Path from an accepted distance beat to its weight beat: input register,
// two 12-stage dividers, ring offset register, two curve stages and a 12-stage square root.
// Throughput: one beat per cycle, since every stage is pipelined; the whole pipeline holds
// while the output beat waits.
// Reset: synchronous, clears all valid bits and loads radius 2560,
// falloff 2048 and the linear curve.
module radial_brush_falloff_weight_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [bfw_pkg::IN_W-1:0]  s_tdata,   // [15:0] distance
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [bfw_pkg::OUT_W-1:0] m_tdata,   // [12:0] weight, rest zero
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [bfw_pkg::DW-1:0]    cfg_data
);
  import bfw_pkg::*;

  logic [DIST_BITS-1:0] brush_radius;
  logic [FRAC_BITS:0]   falloff_fraction;
  bfw_curve_t           curve_type;

  logic                 en;
  logic                 in_vld;
  logic [DIST_BITS-1:0] in_dist;
  bfw_tag_t             in_tag;

  logic                 n_vld;
  logic [FRAC_BITS-1:0] n_quo;
  bfw_tag_t             n_tag;

  logic [FRAC_BITS:0]   fall;
  logic [FRAC_BITS:0]   start;
  bfw_tag_t             a_tag_next;
  logic                 a_vld;
  logic [FRAC_BITS:0]   a_diff;
  bfw_tag_t             a_tag;

  logic                 t_vld;
  logic [FRAC_BITS-1:0] t_quo;
  bfw_tag_t             t_tag;

  logic                 c_vld;
  bfw_curve_out_t       c_res;

  logic                 q_vld;
  logic [FRAC_BITS:0]   q_weight;

  // Hold the pipeline while the output beat waits
  assign en        = !m_tvalid || m_tready;
  assign s_tready  = en;
  assign cfg_ready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      brush_radius     <= DIST_BITS'(2560);
      falloff_fraction <= (FRAC_BITS + 1)'(2048);
      curve_type       <= CURVE_LINEAR;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RADIUS:  brush_radius     <= cfg_data[DIST_BITS-1:0];
        REG_FALLOFF: falloff_fraction <= cfg_data[FRAC_BITS:0];
        REG_CURVE:   curve_type       <= bfw_curve_t'(cfg_data[1:0]);
        default: ;
      endcase
    end
  end

  // Input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (en) begin
      in_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_dist <= s_tdata[DIST_BITS-1:0];
    end
  end

  assign in_tag.outside = in_dist >= brush_radius;
  assign in_tag.full    = 1'b0;

  // Normalize distance by radius
  bfw_div u_norm_div (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (in_vld),
    .in_rem     (DW'(in_dist)),
    .in_divisor (DW'(brush_radius)),
    .in_tag     (in_tag),
    .out_valid  (n_vld),
    .out_quo    (n_quo),
    .out_tag    (n_tag)
  );

  // Ring start test and offset into the ring
  always_comb begin
    fall  = (falloff_fraction > (FRAC_BITS + 1)'(ONE)) ? (FRAC_BITS + 1)'(ONE)
                                                       : falloff_fraction;
    start = (FRAC_BITS + 1)'(ONE) - fall;
    a_tag_next.outside = n_tag.outside;
    a_tag_next.full    = {1'b0, n_quo} <= start;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (en) begin
      a_vld <= n_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_diff <= {1'b0, n_quo} - start;
      a_tag  <= a_tag_next;
    end
  end

  // Position across the ring
  bfw_div u_ring_div (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (a_vld),
    .in_rem     (DW'(a_diff)),
    .in_divisor (DW'(fall)),
    .in_tag     (a_tag),
    .out_valid  (t_vld),
    .out_quo    (t_quo),
    .out_tag    (t_tag)
  );

  bfw_curve u_curve (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (t_vld),
    .in_t      (t_quo),
    .in_tag    (t_tag),
    .curve     (curve_type),
    .out_valid (c_vld),
    .out_res   (c_res)
  );

  bfw_sqrt u_sqrt (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (c_vld),
    .in_res     (c_res),
    .out_valid  (q_vld),
    .out_weight (q_weight)
  );

  assign m_tvalid = q_vld;
  assign m_tdata  = OUT_W'(q_weight);

  // Weight never exceeds full strength
  a_weight_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[FRAC_BITS:0] <= (FRAC_BITS + 1)'(ONE)))
    else $error("weight above full strength");

  // Input is taken exactly when the pipeline advances
  a_ready_follows: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready out of step with output stall");

  // Nothing leaves right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output beat right after reset");

  // A stalled pipeline keeps its output weight
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(q_weight)))
    else $error("weight changed during stall");

endmodule

### dv/radial_brush_falloff_weight_unit_tb.sv
// Testbench for the radial brush falloff weight unit: directed and random distances against a predictor.
`timescale 1ns / 1ps

module radial_brush_falloff_weight_unit_tb;
  import bfw_pkg::*;

  // Index with no register behind it
  localparam logic [1:0] REG_NONE = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [IN_W-1:0]      s_tdata = '0;   // [15:0] distance
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [OUT_W-1:0]     m_tdata;        // [12:0] weight
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [1:0]           cfg_index = '0;
  logic [DW-1:0]        cfg_data = '0;

  // Predictor copy of the registers
  logic [DIST_BITS-1:0] radius_q;
  logic [FRAC_BITS:0]   falloff_q;
  bfw_curve_t           curve_q;

  logic [FRAC_BITS:0]   weight_q[$];
  int                   send_idle_pct;
  int                   recv_idle_pct;
  int                   hold_seq = 0;
  int                   hold_seen = 0;
  int                   hold_cycles = 0;
  int                   n_errors = 0;

  radial_brush_falloff_weight_unit u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    #50_000_000;
    $display("FAILURE");
    $finish;
  end

  // Integer square root by exhaustive bit setting
  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned r;
    r = 0;
    for (int b = 16; b >= 0; b--) begin
      if ((r + (64'd1 << b)) * (r + (64'd1 << b)) <= v) r = r + (64'd1 << b);
    end
    return r;
  endfunction

  // Cosine curve from the Q1.16 table with rounded interpolation
  function automatic longint unsigned cosine_weight(input longint unsigned t);
    longint unsigned p, idx, fr, a, b, v;
    p = t << TAB_SHIFT;
    idx = p >> 12;
    fr = p & 4095;
    if (idx >= 16) begin
      v = cos_tab(5'd16);
    end else begin
      a = cos_tab(idx[4:0]);
      b = cos_tab(idx[4:0] + 5'd1);
      v = a - (((a - b) * fr + 2048) >> 12);
    end
    return (v + HALF_TAB) >> TAB_SHIFT;
  endfunction

  // Expected weight of one distance under the current registers
  function automatic logic [FRAC_BITS:0] falloff_weight(input logic [DIST_BITS-1:0] d);
    longint unsigned fall, start, n, t, w, r;
    fall = (falloff_q > ONE) ? ONE : falloff_q;
    start = ONE - fall;
    if (d >= radius_q) return '0;
    n = (longint'(d) << FRAC_BITS) / radius_q;
    if (n <= start) return (FRAC_BITS + 1)'(ONE);
    t = ((n - start) << FRAC_BITS) / fall;
    if (t > ONE) t = ONE;
    case (curve_q)
      CURVE_COSINE: w = cosine_weight(t);
      CURVE_SPHERE: w = root_floor(ONE * ONE - t * t);
      CURVE_TIP: begin
        r = ONE - t;
        w = (r * r + (ONE >> 1)) >> FRAC_BITS;
      end
      default: w = ONE - t;
    endcase
    if (w > ONE) w = ONE;
    return w[FRAC_BITS:0];
  endfunction

  // Receiver: random stall, long hold-off on request; check each beat
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (weight_q.size() == 0) begin
          $display("%0t: unexpected weight beat %0d", $time, m_tdata);
          n_errors++;
        end else begin
          if (m_tdata !== {{(OUT_W-FRAC_BITS-1){1'b0}}, weight_q[0]}) begin
            $display("%0t: weight expected %0d actual %0d", $time, weight_q[0], m_tdata);
            n_errors++;
          end
          void'(weight_q.pop_front());
        end
      end
      if (hold_seq != hold_seen) begin
        hold_seen   <= hold_seq;
        hold_cycles <= 200;
        m_tready    <= 1'b0;
      end else if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Write one register while idle
  task automatic write_reg(input logic [1:0] idx, input logic [DW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_RADIUS:  radius_q  = val[DIST_BITS-1:0];
      REG_FALLOFF: falloff_q = val[FRAC_BITS:0];
      REG_CURVE:   curve_q   = bfw_curve_t'(val[1:0]);
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_brush(input int rad, input int fall, input bfw_curve_t c);
    write_reg(REG_RADIUS, DW'(rad));
    write_reg(REG_FALLOFF, DW'(fall));
    write_reg(REG_CURVE, DW'(c));
  endtask

  // Send one distance beat, with random idle cycles first
  task automatic send_distance(input logic [DIST_BITS-1:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_W'(d);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    weight_q.insert(weight_q.size(), falloff_weight(d));
  endtask

  // Drop valid and wait until every expected weight has come back
  task automatic drain;
    s_tvalid <= 1'b0;
    while (weight_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  // Distance mostly inside the radius so the ring is exercised
  function automatic logic [DIST_BITS-1:0] pick_distance;
    if ($urandom_range(9) == 0) return DIST_BITS'($urandom_range(65535));
    if (radius_q == 0) return DIST_BITS'($urandom_range(3));
    return DIST_BITS'($urandom_range(radius_q + (radius_q >> 3)));
  endfunction

  task automatic test_directed;
    set_brush(2560, 2048, CURVE_LINEAR);
    send_distance(0);
    send_distance(16'hFFFF);
    send_distance(2559);
    send_distance(2560);
    send_distance(1280);
    send_distance(1281);
    drain();
    for (int c = 0; c < 4; c++) begin
      set_brush(65535, 4096, bfw_curve_t'(c));
      send_distance(65534);
      send_distance(32768);
      send_distance(16'h5555);
      drain();
    end
    // zero radius, zero falloff, falloff above one, oversized and unknown writes
    set_brush(0, 8191, CURVE_SPHERE);
    send_distance(0);
    drain();
    write_reg(REG_RADIUS, 16'hAAAA);
    write_reg(REG_FALLOFF, '0);
    send_distance(16'h1234);
    drain();
    write_reg(REG_FALLOFF, 16'hFFFF);
    write_reg(REG_CURVE, 16'hFFFE);
    write_reg(REG_NONE, 16'h1234);
    send_distance(16'h9999);
    send_distance(16'hA000);
    drain();
  endtask

  task automatic test_random(input int items);
    for (int i = 0; i < items; i++) begin
      if (i % 70 == 0) begin
        drain();
        set_brush($urandom_range(3) == 0 ? $urandom_range(65535) : $urandom_range(4000, 256),
                  $urandom_range(4) == 0 ? $urandom_range(8191) : $urandom_range(4096),
                  bfw_curve_t'($urandom_range(3)));
      end
      send_distance(pick_distance());
    end
    drain();
  endtask

  // Receiver holds off while the sender fills the pipeline
  task automatic test_backpressure;
    hold_seq = hold_seq + 1;
    for (int i = 0; i < 80; i++) send_distance(pick_distance());
    drain();
  endtask

  initial begin
    send_idle_pct = 31;
    recv_idle_pct = 67;
    radius_q = 2560;
    falloff_q = 2048;
    curve_q = CURVE_LINEAR;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(280);
    send_idle_pct = 67;
    recv_idle_pct = 31;
    test_random(280);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random(200);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
